FILE: design/trs_pkg.sv
// Shared types and constants of the text run segmenter.
package trs_pkg;

   typedef enum logic [1:0] {
      OP_NORMAL    = 2'd0,
      OP_SPACER    = 2'd1,
      OP_INVISIBLE = 2'd2,
      OP_END_ROW   = 2'd3
   } op_type;

   typedef enum logic {
      KIND_BOUNDARY = 1'b0,
      KIND_CLOSE    = 1'b1
   } kind_type;

   localparam logic [4:0]  MAX_CELL_UNITS = 5'd31;
   localparam logic [14:0] TEXT_MAX       = 15'h7fff;
   localparam logic [10:0] COUNT_MAX      = 11'h7ff;

   localparam logic [20:0] CP_F = 21'h66;
   localparam logic [20:0] CP_I = 21'h69;
   localparam logic [20:0] CP_L = 21'h6c;
   localparam logic [20:0] CP_S = 21'h73;
   localparam logic [20:0] CP_T = 21'h74;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      op_type      operation;
      logic [4:0]  text_units;
      logic [7:0]  font_id;
      logic [23:0] fg_color;
      logic [31:0] style_word;
      logic [20:0] base_codepoint;
      logic [9:0]  column;
      logic [1:0]  column_span;
      logic        plain_codepoint;
      logic        extended_grapheme;
      logic        cursor_here;
   } cell_type;

   typedef struct packed {
      kind_type    kind;
      logic [14:0] text_position;
      logic [10:0] end_column;
      logic        tentative;
      logic [9:0]  run_start;
      logic [7:0]  run_font;
      logic [23:0] run_color;
      logic [31:0] run_style;
      logic [10:0] kept_boundaries;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] push_count;
      result_type res_0;
      result_type res_1;
   } core_out_type;

endpackage

FILE: design/trs_core.sv
// Run state and the per-cell segmentation logic.
module trs_core import trs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         break_at_cursor,
   input  logic         advance,
   input  cell_type     grid_cell,
   output core_out_type core_out
);

   logic        run_open_ff, run_open_in;
   logic [7:0]  open_font_ff, open_font_in;
   logic [23:0] open_color_ff, open_color_in;
   logic [31:0] open_style_ff, open_style_in;
   logic [9:0]  open_start_ff, open_start_in;
   logic [14:0] text_count_ff, text_count_in;
   logic [14:0] kept_text_ff, kept_text_in;
   logic [10:0] kept_span_ff, kept_span_in;
   logic [10:0] kept_count_ff, kept_count_in;
   logic [10:0] boundary_total_ff, boundary_total_in;
   logic        prior_valid_ff, prior_valid_in;
   logic [20:0] prior_codepoint_ff, prior_codepoint_in;
   logic [9:0]  prior_column_ff, prior_column_in;
   logic [1:0]  prior_span_ff, prior_span_in;
   logic [2:0]  prior_flags_ff, prior_flags_in;

   logic        is_normal, is_close_op;
   logic [4:0]  units, add;
   logic [1:0]  prior_lspan, cell_span;
   logic        adjacent, ligature, prior_cursor, cell_cursor, compatible;
   logic        do_break, close_req, close_emit, open_mid, start, bnd_emit, tent;
   logic [14:0] base_text, text_new;
   logic [15:0] text_sum;
   logic [10:0] base_total, total_new, end_col;
   logic [9:0]  new_start;
   logic [7:0]  new_font;
   logic [23:0] new_color;
   logic [31:0] new_style;
   result_type  close_res, bnd_res;

   always_comb begin
      is_normal   = grid_cell.operation == OP_NORMAL;
      is_close_op = grid_cell.operation == OP_INVISIBLE ||
                    grid_cell.operation == OP_END_ROW;
      units       = (grid_cell.text_units > MAX_CELL_UNITS) ? MAX_CELL_UNITS :
                                                               grid_cell.text_units;
      prior_lspan = (prior_span_ff == 2'd0) ? 2'd1 : prior_span_ff;
      cell_span   = (grid_cell.column_span == 2'd0) ? 2'd1 : grid_cell.column_span;

      adjacent = ({1'b0, prior_column_ff} + {9'b0, prior_lspan}) == {1'b0, grid_cell.column};
      ligature = prior_flags_ff[0] && grid_cell.plain_codepoint &&
                 ((prior_codepoint_ff == CP_F &&
                   (grid_cell.base_codepoint == CP_I || grid_cell.base_codepoint == CP_L)) ||
                  (prior_codepoint_ff == CP_S && grid_cell.base_codepoint == CP_T));
      prior_cursor = prior_flags_ff[2] && !prior_flags_ff[1];
      cell_cursor  = grid_cell.cursor_here && !grid_cell.extended_grapheme;
      compatible   = adjacent && open_font_ff == grid_cell.font_id &&
                     open_color_ff == grid_cell.fg_color &&
                     open_style_ff == grid_cell.style_word &&
                     !ligature && !(break_at_cursor && (prior_cursor || cell_cursor));

      do_break   = is_normal && run_open_ff && prior_valid_ff && !compatible;
      close_req  = (is_close_op || do_break) && run_open_ff;
      close_emit = close_req && kept_count_ff != 11'd0;
      open_mid   = run_open_ff && !close_req;
      start      = is_normal && !open_mid && units != 5'd0;
      bnd_emit   = is_normal && (open_mid || start);
      tent       = units == 5'd0;
      add        = tent ? 5'd1 : units;

      base_text  = start ? 15'd0 : text_count_ff;
      base_total = start ? 11'd0 : boundary_total_ff;
      text_sum   = {1'b0, base_text} + {11'b0, add};
      text_new   = (text_sum > {1'b0, TEXT_MAX}) ? TEXT_MAX : text_sum[14:0];
      total_new  = (base_total < COUNT_MAX) ? base_total + 11'd1 : base_total;

      new_start = start ? grid_cell.column     : open_start_ff;
      new_font  = start ? grid_cell.font_id    : open_font_ff;
      new_color = start ? grid_cell.fg_color   : open_color_ff;
      new_style = start ? grid_cell.style_word : open_style_ff;
      end_col   = {1'b0, grid_cell.column} + {9'b0, cell_span} - {1'b0, new_start};

      close_res.kind            = KIND_CLOSE;
      close_res.text_position   = kept_text_ff;
      close_res.end_column      = kept_span_ff;
      close_res.tentative       = 1'b0;
      close_res.run_start       = open_start_ff;
      close_res.run_font        = open_font_ff;
      close_res.run_color       = open_color_ff;
      close_res.run_style       = open_style_ff;
      close_res.kept_boundaries = kept_count_ff;
      close_res.last            = !bnd_emit;

      bnd_res.kind            = KIND_BOUNDARY;
      bnd_res.text_position   = text_new;
      bnd_res.end_column      = end_col;
      bnd_res.tentative       = tent;
      bnd_res.run_start       = new_start;
      bnd_res.run_font        = new_font;
      bnd_res.run_color       = new_color;
      bnd_res.run_style       = new_style;
      bnd_res.kept_boundaries = total_new;
      bnd_res.last            = 1'b1;

      core_out.push_count = {1'b0, close_emit} + {1'b0, bnd_emit};
      core_out.res_0      = close_emit ? close_res : bnd_res;
      core_out.res_1      = bnd_res;
   end

   always_comb begin
      run_open_in        = run_open_ff;
      open_font_in       = open_font_ff;
      open_color_in      = open_color_ff;
      open_style_in      = open_style_ff;
      open_start_in      = open_start_ff;
      text_count_in      = text_count_ff;
      kept_text_in       = kept_text_ff;
      kept_span_in       = kept_span_ff;
      kept_count_in      = kept_count_ff;
      boundary_total_in  = boundary_total_ff;
      prior_valid_in     = prior_valid_ff;
      prior_codepoint_in = prior_codepoint_ff;
      prior_column_in    = prior_column_ff;
      prior_span_in      = prior_span_ff;
      prior_flags_in     = prior_flags_ff;
      if (advance && is_close_op) begin
         run_open_in    = 1'b0;
         prior_valid_in = 1'b0;
      end
      if (advance && is_normal) begin
         run_open_in   = open_mid || start;
         open_font_in  = new_font;
         open_color_in = new_color;
         open_style_in = new_style;
         open_start_in = new_start;
         if (bnd_emit) begin
            text_count_in     = text_new;
            boundary_total_in = total_new;
            if (!tent) begin
               kept_text_in  = text_new;
               kept_span_in  = end_col;
               kept_count_in = total_new;
            end
         end
         prior_valid_in     = 1'b1;
         prior_codepoint_in = grid_cell.base_codepoint;
         prior_column_in    = grid_cell.column;
         prior_span_in      = grid_cell.column_span;
         prior_flags_in     = {grid_cell.cursor_here, grid_cell.extended_grapheme,
                               grid_cell.plain_codepoint};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff        <= 1'b0;
         open_font_ff       <= '0;
         open_color_ff      <= '0;
         open_style_ff      <= '0;
         open_start_ff      <= '0;
         text_count_ff      <= '0;
         kept_text_ff       <= '0;
         kept_span_ff       <= '0;
         kept_count_ff      <= '0;
         boundary_total_ff  <= '0;
         prior_valid_ff     <= 1'b0;
         prior_codepoint_ff <= '0;
         prior_column_ff    <= '0;
         prior_span_ff      <= '0;
         prior_flags_ff     <= '0;
      end else begin
         run_open_ff        <= run_open_in;
         open_font_ff       <= open_font_in;
         open_color_ff      <= open_color_in;
         open_style_ff      <= open_style_in;
         open_start_ff      <= open_start_in;
         text_count_ff      <= text_count_in;
         kept_text_ff       <= kept_text_in;
         kept_span_ff       <= kept_span_in;
         kept_count_ff      <= kept_count_in;
         boundary_total_ff  <= boundary_total_in;
         prior_valid_ff     <= prior_valid_in;
         prior_codepoint_ff <= prior_codepoint_in;
         prior_column_ff    <= prior_column_in;
         prior_span_ff      <= prior_span_in;
         prior_flags_ff     <= prior_flags_in;
      end
   end

   // A pair of results is always a close followed by the new run's first boundary.
   assert property (@(posedge clock) disable iff (reset)
      core_out.push_count == 2'd2 |->
         core_out.res_0.kind == KIND_CLOSE && core_out.res_1.kind == KIND_BOUNDARY &&
         core_out.res_1.kept_boundaries == 11'd1)
      else $error("close and boundary pair out of order");

   assert property (@(posedge clock) disable iff (reset)
      advance && is_close_op |=> !run_open_ff && !prior_valid_ff)
      else $error("run survived an invisible cell or end of row");

   assert property (@(posedge clock) disable iff (reset)
      run_open_ff |-> kept_count_ff <= boundary_total_ff)
      else $error("kept boundary count exceeds boundary total");

endmodule

FILE: design/trs_out_queue.sv
// Result queue: up to two results in per cycle, one out when pop_ready.
module trs_out_queue import trs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_en,
   input  logic [1:0] push_count,
   input  result_type push_0,
   input  result_type push_1,
   input  logic       pop_ready,
   output logic       head_valid,
   output result_type head,
   output logic       room
);

   result_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [QCNT_W-1:0] count_ff, count_in, push_n;
   logic              pop;

   always_comb begin
      head_valid = count_ff != '0;
      head       = entry_ff[rd_ptr_ff];
      room       = count_ff <= QCNT_W'(QUEUE_DEPTH - 2);
      pop        = head_valid && pop_ready;
      push_n     = push_en ? QCNT_W'(push_count) : '0;
      wr_next    = wr_ptr_ff + QPTR_W'(1);
      wr_ptr_in  = wr_ptr_ff + push_n[QPTR_W-1:0];
      rd_ptr_in  = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff + push_n - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != '0) begin
         entry_ff[wr_ptr_ff] <= push_0;
      end
      if (push_n == QCNT_W'(2)) begin
         entry_ff[wr_next] <= push_1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      push_n != '0 |-> room)
      else $error("results pushed without room for a pair");

endmodule

FILE: design/text_run_segmenter.sv
// Top level of the text run segmenter: input register, run logic and result queue.
//
// The segmenter takes one row cell per clock while the result queue has room
// and groups cells into shaping runs. A cell is registered on arrival and is
// processed once the queue has room; its results are registered in the queue
// before they leave. Most cells give one result, spacers none; a cell that closes
// one run and opens another gives two. The port delivers one result per cycle
// while rsp_tready is set. A four-entry result queue decouples the two sides, so a
// new cell is taken while earlier results still wait. Run-close results carry
// the span trimmed to the last non-empty cell; boundaries of empty cells are
// flagged tentative. csr_data bit 0 enables run breaks around cursor cells and
// should be written only while no cell is in flight.
module text_run_segmenter import trs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // text_units, font_id, fg_color, style_word, base_codepoint, column,
   // column_span, plain_codepoint, extended_grapheme, cursor_here, zero fill
   input  logic [111:0] req_tdata,
   // operation
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // text_position, end_column, tentative, run_start, run_font, run_color,
   // run_style, kept_boundaries
   output logic [111:0] rsp_tdata,
   // kind
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   logic         in_valid_ff, in_valid_in;
   cell_type     in_cell_ff, in_cell_in;
   logic         break_at_cursor_ff, break_at_cursor_in;
   logic         advance, room, req_accept;
   core_out_type core_out;
   result_type   head;

   always_comb begin
      in_cell_in.operation         = op_type'(req_tuser);
      in_cell_in.text_units        = req_tdata[4:0];
      in_cell_in.font_id           = req_tdata[12:5];
      in_cell_in.fg_color          = req_tdata[36:13];
      in_cell_in.style_word        = req_tdata[68:37];
      in_cell_in.base_codepoint    = req_tdata[89:69];
      in_cell_in.column            = req_tdata[99:90];
      in_cell_in.column_span       = req_tdata[101:100];
      in_cell_in.plain_codepoint   = req_tdata[102];
      in_cell_in.extended_grapheme = req_tdata[103];
      in_cell_in.cursor_here       = req_tdata[104];

      advance     = in_valid_ff && room;
      req_tready  = !reset && (!in_valid_ff || advance);
      req_accept  = req_tvalid && req_tready;
      in_valid_in = req_accept || (in_valid_ff && !advance);

      csr_ready          = !reset;
      break_at_cursor_in = (csr_valid && csr_ready) ? csr_data : break_at_cursor_ff;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cell_ff <= in_cell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         break_at_cursor_ff <= 1'b0;
      end else begin
         in_valid_ff        <= in_valid_in;
         break_at_cursor_ff <= break_at_cursor_in;
      end
   end

   trs_core u_core (
      .clock           (clock),
      .reset           (reset),
      .break_at_cursor (break_at_cursor_ff),
      .advance         (advance),
      .grid_cell       (in_cell_ff),
      .core_out        (core_out)
   );

   trs_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (advance),
      .push_count (core_out.push_count),
      .push_0     (core_out.res_0),
      .push_1     (core_out.res_1),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .room       (room)
   );

   assign rsp_tdata = {head.kept_boundaries, head.run_style, head.run_color, head.run_font,
                       head.run_start, head.tentative, head.end_column, head.text_position};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room |=> in_valid_ff && $stable(in_cell_ff))
      else $error("held cell lost while the result queue was full");

endmodule
